// ----- rtl/qlmr_pkg.sv -----
// Shared types, constants and helper functions of the Q-routing mesh router.
`timescale 1ns / 1ps

package qlmr_pkg;

    // Sizing of the estimate store
    localparam int MESH_TILES = 64;
    localparam int MAX_PORTS = 4;
    localparam int EST_WIDTH = 16;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int DIR_W   = 3;
    localparam int DEST_W  = 6;
    localparam int RND_W   = 12;
    localparam int NEST_W  = 16;
    localparam int DELAY_W = 16;
    localparam int MIN_W   = 16;
    localparam int NBR_W   = 3;
    localparam int COLS_W  = 7;
    localparam int ALPHA_W = 9;

    // Derived widths
    localparam int TILE_W  = $clog2(MESH_TILES);
    localparam int PORT_W  = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int CNT_W   = $clog2(MAX_PORTS + 1);
    localparam int DEPTH   = MAX_PORTS * MESH_TILES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DEST_LUT = 2 ** DEST_W;

    // Divider: a random draw is the widest dividend, a column count the widest divisor
    localparam int DIV_W  = RND_W;
    localparam int DVSR_W = COLS_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    // Estimate blend arithmetic
    localparam int VAL_W = (EST_WIDTH > NEST_W) ? EST_WIDTH : NEST_W;
    localparam int ACC_W = ALPHA_W + EST_WIDTH;
    localparam int MIX_W = ALPHA_W + VAL_W + 1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
    localparam int ALPHA_SHIFT = 8;

    localparam int INIT_EST = 20;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ROUTE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_N = 3'd0;
    localparam logic [DIR_W-1:0] DIR_S = 3'd1;
    localparam logic [DIR_W-1:0] DIR_E = 3'd2;
    localparam logic [DIR_W-1:0] DIR_W_ = 3'd3;
    localparam logic [DIR_W-1:0] DIR_C = 3'd4;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_OWN_TILE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_NBR    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MESH_COLS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EXPLORE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DELAY  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_EST    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA      = 3'd6;

    typedef struct packed {
        logic [DEST_W-1:0]  own_tile;
        logic [NBR_W-1:0]   num_neighbors;
        logic [COLS_W-1:0]  mesh_columns;
        logic [RND_W-1:0]   explore_threshold;
        logic [DELAY_W-1:0] max_delay;
        logic [NEST_W-1:0]  max_estimate;
        logic [ALPHA_W-1:0] alpha_fixed;
    } cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [DIR_W-1:0]   in_dir;
        logic [DEST_W-1:0]  dest_tile;
        logic [RND_W-1:0]   random_value;
        logic [NEST_W-1:0]  neighbor_estimate;
        logic [DELAY_W-1:0] delay_sample;
    } item_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic scan;
        logic upd_read;
        logic upd_mul1;
        logic upd_mul2;
        logic upd_write;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic q_path;
        logic dest_own;
        logic port_ok;
        logic explore;
        logic div_busy;
        logic scan_last;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_SCAN,
        ST_SCAN_END,
        ST_UPD_READ,
        ST_UPD_MUL1,
        ST_UPD_MUL2,
        ST_UPD_WRITE,
        ST_FINISH
    } state_t;

    // Destination tile to table column (tile mod MESH_TILES), built at elaboration
    typedef logic [TILE_W-1:0] col_lut_t [DEST_LUT];

    function automatic col_lut_t build_col_lut();
        col_lut_t lut;
        for (int i = 0; i < DEST_LUT; i++)
        begin
            lut[i] = TILE_W'(i % MESH_TILES);
        end
        return lut;
    endfunction

    localparam col_lut_t COL_LUT = build_col_lut();

    // Neighbor count in use: 0 acts as 1, counts above MAX_PORTS clip
    function automatic logic [CNT_W-1:0] eff_neighbors(input logic [NBR_W-1:0] num);
        logic [CNT_W-1:0] n;
        if (num == '0)
            n = CNT_W'(1);
        else if (int'(num) > MAX_PORTS)
            n = CNT_W'(MAX_PORTS);
        else
            n = CNT_W'(num);
        return n;
    endfunction

endpackage

// ----- rtl/qlmr_div.sv -----
// Two-lane restoring divider, one quotient bit per lane per cycle.
`timescale 1ns / 1ps

module qlmr_div
    import qlmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] steps,
    input  logic [DIV_W-1:0]  dividend_a,
    input  logic [DIV_W-1:0]  dividend_b,
    input  logic [DVSR_W-1:0] divisor,
    output logic              busy,
    output logic [DIV_W-1:0]  quot_a,
    output logic [DIV_W-1:0]  quot_b,
    output logic [DVSR_W-1:0] rem_a,
    output logic [DVSR_W-1:0] rem_b
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  dvd_a_reg, dvd_b_reg;
    logic [DVSR_W-1:0] rem_a_reg, rem_b_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [DVSR_W+DIV_W-1:0] step_a, step_b;

    // One restoring step: returns {remainder, shifted dividend with new quotient bit}
    function automatic logic [DVSR_W+DIV_W-1:0] div_step(
        input logic [DVSR_W-1:0] rem,
        input logic [DIV_W-1:0]  dvd,
        input logic [DVSR_W-1:0] dvsr
    );
        logic [DVSR_W:0]   trial;
        logic              ge;
        logic [DVSR_W-1:0] rem_n;
        trial = {rem, dvd[DIV_W-1]};
        ge    = (trial >= {1'b0, dvsr});
        rem_n = ge ? DVSR_W'(trial - {1'b0, dvsr}) : trial[DVSR_W-1:0];
        return {rem_n, dvd[DIV_W-2:0], ge};
    endfunction

    assign step_a = div_step(rem_a_reg, dvd_a_reg, dvsr_reg);
    assign step_b = div_step(rem_b_reg, dvd_b_reg, dvsr_reg);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_a_reg <= dividend_a;
            dvd_b_reg <= dividend_b;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            dvsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            {rem_a_reg, dvd_a_reg} <= step_a;
            {rem_b_reg, dvd_b_reg} <= step_b;
        end
    end

    assign busy   = busy_reg;
    assign quot_a = dvd_a_reg;
    assign quot_b = dvd_b_reg;
    assign rem_a  = rem_a_reg;
    assign rem_b  = rem_b_reg;

endmodule

// ----- rtl/qlmr_datapath.sv -----
// Datapath: item registers, estimate memory, scan, blend arithmetic and result register.
`timescale 1ns / 1ps

module qlmr_datapath
    import qlmr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             table_clear,
    input  item_t            item,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [DIR_W-1:0] next_dir,
    output logic [MIN_W-1:0] min_estimate
);

    // Latched item
    logic [REQ_W-1:0]   req_reg;
    logic [DIR_W-1:0]   dir_reg;
    logic [DEST_W-1:0]  dest_reg;
    logic [TILE_W-1:0]  col_reg;
    logic [RND_W-1:0]   rnd_reg;
    logic [NEST_W-1:0]  nest_reg;
    logic [DELAY_W-1:0] d_reg;

    // Estimate store and its read side
    logic [EST_WIDTH-1:0] est_mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [EST_WIDTH-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [ADDR_W-1:0]    rd_addr, upd_addr, scan_addr;
    logic                 rd_en;
    logic [EST_WIDTH-1:0] est_rd;
    logic                 own_hit;

    // Scan
    logic [PORT_W-1:0]    scan_cnt_reg;
    logic                 rd_pending_reg;
    logic [PORT_W-1:0]    rd_idx_reg;
    logic [EST_WIDTH-1:0] min_reg;
    logic [PORT_W-1:0]    first_reg;
    logic [EST_WIDTH-1:0] sval_reg;

    // Update
    logic [NEST_W-1:0]    e_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [EST_WIDTH-1:0] new_reg;
    logic [NEST_W:0]      e_sum;
    logic [ALPHA_W-1:0]   a_sat, a_rest;
    logic [MIX_W-1:0]     mix;

    // Output
    logic             out_valid_reg;
    logic [DIR_W-1:0] out_dir_reg;
    logic [MIN_W-1:0] out_min_reg;

    // Divider
    logic              div_busy;
    logic [DIV_W-1:0]  quot_a, quot_b;
    logic [DVSR_W-1:0] rem_a, rem_b;
    logic [DIV_W-1:0]  dividend_a, dividend_b;
    logic [DVSR_W-1:0] divisor;
    logic [STEP_W-1:0] steps;

    logic [CNT_W-1:0]  n_eff;
    logic [COLS_W-1:0] cols_eff;
    logic              q_path, dest_own, port_ok, explore;
    logic [PORT_W-1:0] s_idx, q_best;
    logic [DIR_W-1:0]  xy_dir, dir_res;
    logic [MIN_W-1:0]  min_res;

    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [PORT_W-1:0] port,
        input logic [TILE_W-1:0] col
    );
        return ADDR_W'(int'(port) * MESH_TILES + int'(col));
    endfunction

    assign n_eff    = eff_neighbors(cfg.num_neighbors);
    assign cols_eff = (cfg.mesh_columns == '0) ? COLS_W'(1) : cfg.mesh_columns;
    assign q_path   = (dir_reg == '0);
    assign dest_own = (dest_reg == cfg.own_tile);
    assign port_ok  = (int'(dir_reg) < int'(n_eff));
    assign explore  = (rnd_reg <= cfg.explore_threshold);

    // Item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= item.req_type;
            dir_reg  <= item.in_dir;
            dest_reg <= item.dest_tile;
            col_reg  <= COL_LUT[item.dest_tile];
            rnd_reg  <= item.random_value;
            nest_reg <= item.neighbor_estimate;
            d_reg    <= (item.delay_sample > cfg.max_delay) ? cfg.max_delay
                                                            : item.delay_sample;
        end
    end

    // Q path divides the draw by the port count; XY divides both tiles by the columns
    assign dividend_a = q_path ? rnd_reg : {cfg.own_tile, {(DIV_W - DEST_W){1'b0}}};
    assign dividend_b = {dest_reg, {(DIV_W - DEST_W){1'b0}}};
    assign divisor    = q_path ? DVSR_W'(n_eff) : cols_eff;
    assign steps      = q_path ? STEP_W'(DIV_W) : STEP_W'(DEST_W);

    qlmr_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.div_start),
        .steps      (steps),
        .dividend_a (dividend_a),
        .dividend_b (dividend_b),
        .divisor    (divisor),
        .busy       (div_busy),
        .quot_a     (quot_a),
        .quot_b     (quot_b),
        .rem_a      (rem_a),
        .rem_b      (rem_b)
    );

    assign s_idx = PORT_W'(rem_a);

    // XY decision: column first, then row
    always_comb
    begin
        if (rem_b > rem_a)
            xy_dir = DIR_E;
        else if (rem_b < rem_a)
            xy_dir = DIR_W_;
        else if (quot_b[DEST_W-1:0] < quot_a[DEST_W-1:0])
            xy_dir = DIR_N;
        else if (quot_b[DEST_W-1:0] > quot_a[DEST_W-1:0])
            xy_dir = DIR_S;
        else
            xy_dir = DIR_C;
    end

    // Memory read port
    assign scan_addr = entry_addr(scan_cnt_reg, col_reg);
    assign upd_addr  = entry_addr(PORT_W'(dir_reg), col_reg);
    assign rd_addr   = cmd.scan ? scan_addr : upd_addr;
    assign rd_en     = cmd.scan | cmd.upd_read;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= est_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (cmd.upd_write)
            est_mem[upd_addr] <= new_reg;
    end

    // Unwritten entries read as the initial estimate, own column as zero
    assign own_hit = (col_reg == COL_LUT[cfg.own_tile]);
    assign est_rd  = rd_valid_reg ? rd_data_reg
                   : (own_hit ? '0 : EST_WIDTH'(INIT_EST));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (table_clear)
            valid_reg <= '0;
        else if (cmd.upd_write)
            valid_reg[upd_addr] <= 1'b1;
    end

    // Scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg   <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            rd_pending_reg <= cmd.scan;
            if (cmd.load)
                scan_cnt_reg <= '0;
            else if (cmd.scan)
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    // Running minimum, first index holding it, and the start candidate's value
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
            rd_idx_reg <= scan_cnt_reg;
        if (rd_pending_reg)
        begin
            if (rd_idx_reg == '0 || est_rd < min_reg)
            begin
                min_reg   <= est_rd;
                first_reg <= rd_idx_reg;
            end
            if (rd_idx_reg == s_idx)
                sval_reg <= est_rd;
        end
    end

    assign q_best = (sval_reg == min_reg) ? s_idx : first_reg;

    // Blend: ((256 - a) * old + a * e) >> 8
    assign a_sat  = (cfg.alpha_fixed > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_fixed;
    assign a_rest = ALPHA_ONE - a_sat;
    assign e_sum  = {1'b0, nest_reg} + {1'b0, d_reg};
    assign mix    = MIX_W'(acc_reg) + MIX_W'(a_sat) * MIX_W'(e_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.upd_read)
            e_reg <= (e_sum > {1'b0, cfg.max_estimate}) ? cfg.max_estimate
                                                         : e_sum[NEST_W-1:0];
        if (cmd.upd_mul1)
            acc_reg <= ACC_W'(a_rest) * ACC_W'(est_rd);
        if (cmd.upd_mul2)
            new_reg <= mix[EST_WIDTH+ALPHA_SHIFT-1:ALPHA_SHIFT];
    end

    // Result selection
    always_comb
    begin
        dir_res = '0;
        min_res = '0;
        case (req_reg)
            REQ_ROUTE:
            begin
                if (!q_path)
                    dir_res = xy_dir;
                else if (dest_own)
                    dir_res = DIR_W'(n_eff);
                else if (explore)
                    dir_res = DIR_W'(s_idx);
                else
                    dir_res = DIR_W'(q_best);
            end
            REQ_QUERY:
                min_res = MIN_W'(min_reg);
            default:
            begin
                dir_res = '0;
                min_res = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_dir_reg <= dir_res;
            out_min_reg <= min_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_dir     = out_dir_reg;
    assign min_estimate = out_min_reg;

    assign status.req_type  = req_reg;
    assign status.q_path    = q_path;
    assign status.dest_own  = dest_own;
    assign status.port_ok   = port_ok;
    assign status.explore   = explore;
    assign status.div_busy  = div_busy;
    assign status.scan_last = (CNT_W'(scan_cnt_reg) == n_eff - 1'b1);
    assign status.out_free  = !out_valid_reg || out_ready;

`ifndef SYNTHESIS
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_write |-> port_ok)
        else $error("estimate write to a port outside the neighbor count");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (int'(scan_cnt_reg) < int'(n_eff)))
        else $error("scan read beyond the neighbor count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while holding an untaken item");
`endif

endmodule

// ----- rtl/qlmr_ctrl.sv -----
// Controller state machine sequencing decode, divide, scan and update.
`timescale 1ns / 1ps

module qlmr_ctrl
    import qlmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (status.req_type)
                    REQ_ROUTE:
                    begin
                        if (status.q_path && status.dest_own)
                            state_next = ST_FINISH;
                        else
                            state_next = ST_DIV;
                    end
                    REQ_UPDATE:
                        state_next = status.port_ok ? ST_UPD_READ : ST_FINISH;
                    REQ_QUERY:
                        state_next = ST_SCAN;
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                    state_next = (status.q_path && !status.explore) ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_END:  state_next = ST_FINISH;
            ST_UPD_READ:  state_next = ST_UPD_MUL1;
            ST_UPD_MUL1:  state_next = ST_UPD_MUL2;
            ST_UPD_MUL2:  state_next = ST_UPD_WRITE;
            ST_UPD_WRITE: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE:
            begin
                if (status.req_type == REQ_ROUTE && !(status.q_path && status.dest_own))
                    cmd.div_start = 1'b1;
            end
            ST_SCAN:      cmd.scan      = 1'b1;
            ST_UPD_READ:  cmd.upd_read  = 1'b1;
            ST_UPD_MUL1:  cmd.upd_mul1  = 1'b1;
            ST_UPD_MUL2:  cmd.upd_mul2  = 1'b1;
            ST_UPD_WRITE: cmd.upd_write = 1'b1;
            ST_FINISH:    cmd.out_load  = status.out_free;
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/q_learning_mesh_router_top.sv -----
// Top level of the Q-routing mesh router: stream ports, APB register file, core.
//
//  Channel  Dir  Handshake         Contents
//  s_*      in   s_tvalid/s_tready tuser: req_type; tdata: in_dir, dest_tile, random_value,
//                                  neighbor_estimate, delay_sample
//  m_*      out  m_tvalid/m_tready tdata: next_dir, min_estimate
//  APB      in   psel/penable      seven configuration registers at 4*index
//
//  Time per item, accept to result, grows with the work: a route to the own tile skips the
//  divider, other routes run the bit-serial divider (12 steps on a random draw, 6 on tile
//  numbers), exploit routes and queries scan the n neighbor entries (n = neighbor count in
//  use) through the single read port of the estimate memory, and updates blend one entry.
//  One item is in flight at a time; the result register lets the next item be accepted
//  while a result waits on m_tready. rst_n is asynchronous, active low; the estimate
//  table reads as its initial contents right after reset or an own_tile write, since
//  per-entry valid bits clear at once.
`timescale 1ns / 1ps

module q_learning_mesh_router_top
    import qlmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [2:0] in_dir, [8:3] dest_tile, [20:9] random_value,
                                   // [36:21] neighbor_estimate, [52:37] delay_sample
    input  logic [1:0]  s_tuser,   // [1:0] req_type

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] next_dir, [18:3] min_estimate

    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t                  cfg_reg, cfg_next;
    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  table_clear;
    item_t                 item;
    dp_cmd_t               cmd;
    dp_status_t            status;
    logic                  out_valid;
    logic [DIR_W-1:0]      next_dir;
    logic [MIN_W-1:0]      min_estimate;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Writing own_tile restarts the estimate table
    assign table_clear = cfg_wr && (reg_idx == REG_OWN_TILE);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_OWN_TILE:  cfg_next.own_tile          = pwdata[DEST_W-1:0];
                REG_NUM_NBR:   cfg_next.num_neighbors     = pwdata[NBR_W-1:0];
                REG_MESH_COLS: cfg_next.mesh_columns      = pwdata[COLS_W-1:0];
                REG_EXPLORE:   cfg_next.explore_threshold = pwdata[RND_W-1:0];
                REG_MAX_DELAY: cfg_next.max_delay         = pwdata[DELAY_W-1:0];
                REG_MAX_EST:   cfg_next.max_estimate      = pwdata[NEST_W-1:0];
                REG_ALPHA:     cfg_next.alpha_fixed       = pwdata[ALPHA_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_tile          <= '0;
            cfg_reg.num_neighbors     <= NBR_W'(4);
            cfg_reg.mesh_columns      <= COLS_W'(8);
            cfg_reg.explore_threshold <= RND_W'(300);
            cfg_reg.max_delay         <= DELAY_W'(1000);
            cfg_reg.max_estimate      <= NEST_W'(65535);
            cfg_reg.alpha_fixed       <= ALPHA_W'(128);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_OWN_TILE:  prdata = 32'(cfg_reg.own_tile);
            REG_NUM_NBR:   prdata = 32'(cfg_reg.num_neighbors);
            REG_MESH_COLS: prdata = 32'(cfg_reg.mesh_columns);
            REG_EXPLORE:   prdata = 32'(cfg_reg.explore_threshold);
            REG_MAX_DELAY: prdata = 32'(cfg_reg.max_delay);
            REG_MAX_EST:   prdata = 32'(cfg_reg.max_estimate);
            REG_ALPHA:     prdata = 32'(cfg_reg.alpha_fixed);
            default:       prdata = '0;
        endcase
    end

    // ---------------- request unpacking ----------------
    assign item.req_type          = s_tuser[1:0];
    assign item.in_dir            = s_tdata[2:0];
    assign item.dest_tile         = s_tdata[8:3];
    assign item.random_value      = s_tdata[20:9];
    assign item.neighbor_estimate = s_tdata[36:21];
    assign item.delay_sample      = s_tdata[52:37];

    // ---------------- controller and datapath ----------------
    qlmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qlmr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .table_clear  (table_clear),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (out_valid),
        .next_dir     (next_dir),
        .min_estimate (min_estimate)
    );

    // ---------------- result packing ----------------
    assign m_tvalid = out_valid;
    assign m_tdata  = {5'b0, min_estimate, next_dir};

endmodule

// ----- sim/qlmr_reply_checker.sv -----
// Reply checker for the Q-routing mesh router: tracks registers, predicts and compares replies.
`timescale 1ns / 1ps

module qlmr_reply_checker
    import qlmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // [2:0] in_dir, [8:3] dest_tile, [20:9] random_value,
                                   // [36:21] neighbor_estimate, [52:37] delay_sample
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [2:0] next_dir, [18:3] min_estimate
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          outstanding
);

    typedef struct packed {
        logic [DIR_W-1:0] next_dir;
        logic [MIN_W-1:0] min_estimate;
    } router_reply_t;

    // Shadow registers and estimate table
    logic [DEST_W-1:0]    cfg_own;
    logic [NBR_W-1:0]     cfg_nbr;
    logic [COLS_W-1:0]    cfg_cols;
    logic [RND_W-1:0]     cfg_thr;
    logic [DELAY_W-1:0]   cfg_mdelay;
    logic [NEST_W-1:0]    cfg_mest;
    logic [ALPHA_W-1:0]   cfg_alpha;
    logic [EST_WIDTH-1:0] est_tbl [MAX_PORTS][MESH_TILES];

    router_reply_t replies_due [$];
    int            err_total;

    function automatic void clear_estimates();
        for (int p = 0; p < MAX_PORTS; p++)
        begin
            for (int t = 0; t < MESH_TILES; t++)
            begin
                est_tbl[p][t] = EST_WIDTH'(20);
            end
            est_tbl[p][int'(cfg_own) % MESH_TILES] = '0;
        end
    endfunction

    function automatic int active_ports();
        if (cfg_nbr == 0)
            return 1;
        if (int'(cfg_nbr) > MAX_PORTS)
            return MAX_PORTS;
        return int'(cfg_nbr);
    endfunction

    function automatic logic [DIR_W-1:0] xy_dir(input int dest);
        int cols;
        int row;
        int col;
        int drow;
        int dcol;
        cols = (cfg_cols == 0) ? 1 : int'(cfg_cols);
        row  = int'(cfg_own) / cols;
        col  = int'(cfg_own) % cols;
        drow = dest / cols;
        dcol = dest % cols;
        if (dcol > col) return DIR_E;
        if (dcol < col) return DIR_W_;
        if (drow < row) return DIR_N;
        if (drow > row) return DIR_S;
        return DIR_C;
    endfunction

    function automatic logic [DIR_W-1:0] q_dir(input int dest, input int rnd);
        int n;
        int col;
        int best;
        logic [EST_WIDTH-1:0] best_est;
        n   = active_ports();
        col = dest % MESH_TILES;
        if (dest == int'(cfg_own))
            return DIR_W'(n);
        best = rnd % n;
        if (rnd > int'(cfg_thr))
        begin
            best_est = est_tbl[best][col];
            for (int i = 0; i < n; i++)
            begin
                if (est_tbl[i][col] < best_est)
                begin
                    best_est = est_tbl[i][col];
                    best = i;
                end
            end
        end
        return DIR_W'(best);
    endfunction

    function automatic logic [MIN_W-1:0] lowest_estimate(input int dest);
        int col;
        logic [EST_WIDTH-1:0] m;
        col = dest % MESH_TILES;
        m = est_tbl[0][col];
        for (int i = 1; i < active_ports(); i++)
        begin
            if (est_tbl[i][col] < m)
                m = est_tbl[i][col];
        end
        return MIN_W'(m);
    endfunction

    function automatic void blend_estimate(input int port, input int dest, input int nest,
                                           input int dly);
        int col;
        int d;
        int e;
        int a;
        int old;
        col = dest % MESH_TILES;
        d = (dly > int'(cfg_mdelay)) ? int'(cfg_mdelay) : dly;
        e = nest + d;
        a = (int'(cfg_alpha) > 256) ? 256 : int'(cfg_alpha);
        if (port >= active_ports())
            return;
        if (e > int'(cfg_mest))
            e = int'(cfg_mest);
        old = int'(est_tbl[port][col]);
        est_tbl[port][col] = EST_WIDTH'(((256 - a) * old + a * e) >> 8);
    endfunction

    function automatic router_reply_t compute_reply(input logic [REQ_W-1:0] req,
                                                     input logic [55:0] data);
        router_reply_t r;
        int dir;
        int dest;
        int rnd;
        dir  = int'(data[2:0]);
        dest = int'(data[8:3]);
        rnd  = int'(data[20:9]);
        r = '0;
        if (req == REQ_ROUTE)
            r.next_dir = (dir == 0) ? q_dir(dest, rnd) : xy_dir(dest);
        else if (req == REQ_UPDATE)
            blend_estimate(dir, dest, int'(data[36:21]), int'(data[52:37]));
        else if (req == REQ_QUERY)
            r.min_estimate = lowest_estimate(dest);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        router_reply_t want;
        router_reply_t got;
        if (!rst_n)
        begin
            cfg_own    = '0;
            cfg_nbr    = NBR_W'(4);
            cfg_cols   = COLS_W'(8);
            cfg_thr    = RND_W'(300);
            cfg_mdelay = DELAY_W'(1000);
            cfg_mest   = NEST_W'(65535);
            cfg_alpha  = ALPHA_W'(128);
            clear_estimates();
            replies_due.delete();
            err_total  = 0;
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_OWN_TILE:
                    begin
                        cfg_own = pwdata[DEST_W-1:0];
                        clear_estimates();
                    end
                    REG_NUM_NBR:   cfg_nbr    = pwdata[NBR_W-1:0];
                    REG_MESH_COLS: cfg_cols   = pwdata[COLS_W-1:0];
                    REG_EXPLORE:   cfg_thr    = pwdata[RND_W-1:0];
                    REG_MAX_DELAY: cfg_mdelay = pwdata[DELAY_W-1:0];
                    REG_MAX_EST:   cfg_mest   = pwdata[NEST_W-1:0];
                    REG_ALPHA:     cfg_alpha  = pwdata[ALPHA_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got.next_dir     = m_tdata[2:0];
                got.min_estimate = m_tdata[18:3];
                if (replies_due.size() == 0)
                begin
                    $error("reply with no request outstanding: next_dir %0d min_estimate %0d",
                           got.next_dir, got.min_estimate);
                    err_total++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.next_dir !== want.next_dir)
                    begin
                        $error("next_dir: expected %0d, actual %0d", want.next_dir,
                               got.next_dir);
                        err_total++;
                    end
                    if (got.min_estimate !== want.min_estimate)
                    begin
                        $error("min_estimate: expected %0d, actual %0d", want.min_estimate,
                               got.min_estimate);
                        err_total++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                replies_due.push_back(compute_reply(s_tuser, s_tdata));

            error_count <= err_total;
            outstanding <= replies_due.size();
        end
    end

endmodule

// ----- sim/tb_q_learning_mesh_router_top.sv -----
// Testbench top of the Q-routing mesh router: clock, reset, register setup, request traffic.
`timescale 1ns / 1ps

module tb_q_learning_mesh_router_top;
    import qlmr_pkg::*;

    // Request code with no meaning; the router must answer with all zeros
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    // Every input of the router starts at a known value
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;  // [2:0] in_dir, [8:3] dest_tile, [20:9] random_value,
                                 // [36:21] neighbor_estimate, [52:37] delay_sample
    logic [1:0]  s_tuser  = '0;  // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [2:0] next_dir, [18:3] min_estimate
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int error_count;
    int outstanding;

    // Idling switches for the request and reply sides
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_stall_left = 0;

    q_learning_mesh_router_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    qlmr_reply_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Gap lengths: mostly none or short, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Reply-side backpressure: random stalls while idling is on, else always ready
    always @(posedge clk)
    begin
        if (!rx_idle_on)
        begin
            m_tready <= 1'b1;
            rx_stall_left <= 0;
        end
        else if (rx_stall_left > 0)
        begin
            m_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                rx_stall_left <= idle_gap();
        end
    end

    // One register write: setup phase, then access phase held until pready
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all_regs(input int own, input int nbr, input int cols, input int thr,
                                  input int mdelay, input int mest, input int alpha);
        write_reg(REG_OWN_TILE,  32'(own));
        write_reg(REG_NUM_NBR,   32'(nbr));
        write_reg(REG_MESH_COLS, 32'(cols));
        write_reg(REG_EXPLORE,   32'(thr));
        write_reg(REG_MAX_DELAY, 32'(mdelay));
        write_reg(REG_MAX_EST,   32'(mest));
        write_reg(REG_ALPHA,     32'(alpha));
    endtask

    // Offer one item and hold it until the router takes it.
    // With no gap, tvalid stays high and only the payload changes.
    task automatic send_request(input logic [REQ_W-1:0] req, input int dir, input int dest,
                                input int rnd, input int nest, input int dly);
        int gap;
        gap = tx_idle_on ? idle_gap() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, 16'(dly), 16'(nest), 12'(rnd), 6'(dest), 3'(dir)};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop offering and wait until every reply has come back
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly small values near the table contents, some full range, some extremes
    function automatic int pick_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return $urandom_range(0, 200);
        if (r < 90) return $urandom_range(0, 65535);
        if (r < 95) return 65535;
        return 0;
    endfunction

    initial
    begin
        int own;
        int nbr;
        int cols;
        int thr;
        int mdelay;
        int mest;
        int alpha;
        int r;
        int dir;
        int dest;
        int rnd;
        logic [REQ_W-1:0] req;
        int hot_dest [4];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: tile 0 of an 8-column mesh, four neighbors
        send_request(REQ_ROUTE, 0, 0, 1234, 0, 0);         // own tile: local code
        send_request(REQ_ROUTE, 0, 63, 2999, 0, 0);        // exploit over a tie
        send_request(REQ_ROUTE, 0, 63, 0, 0, 0);           // explore, lowest draw
        send_request(REQ_ROUTE, 0, 10, 300, 0, 0);         // draw at threshold explores
        send_request(REQ_ROUTE, 0, 10, 301, 0, 0);         // just above exploits
        send_request(REQ_ROUTE, 1, 9, 0, 0, 0);            // XY east
        send_request(REQ_ROUTE, 7, 0, 4095, 65535, 65535); // XY to own tile
        send_request(REQ_ROUTE, 2, 8, 0, 0, 0);            // XY south
        send_request(REQ_UPDATE, 0, 10, 0, 65535, 65535);  // delay clamp and ceiling
        send_request(REQ_UPDATE, 3, 10, 0, 0, 0);          // blend toward zero
        send_request(REQ_UPDATE, 4, 10, 0, 5, 5);          // unused port ignored
        send_request(REQ_UPDATE, 7, 10, 0, 5, 5);          // unused port ignored
        send_request(REQ_QUERY, 0, 10, 0, 0, 0);
        send_request(REQ_ROUTE, 0, 10, 2999, 0, 0);        // exploit finds the lowered entry
        send_request(REQ_QUERY, 5, 0, 0, 0, 0);            // own-tile column
        send_request(REQ_QUERY, 0, 63, 4095, 65535, 65535);
        send_request(REQ_UNKNOWN, 7, 63, 4095, 65535, 65535);
        send_request(REQ_UPDATE, 1, 0, 0, 100, 7);         // own-tile column entry
        send_request(REQ_ROUTE, 0, 63, 4095, 0, 0);        // draw beyond the usual range
        drain_replies();

        // Random phases; the first few pin register extremes
        for (int phase = 1; phase <= 8; phase++)
        begin
            case (phase)
                1: write_all_regs(63, 1, 64, 0, 65535, 65535, 256);
                2: write_all_regs(27, 0, 0, 4095, 0, 0, 0);
                3: write_all_regs(9, 7, 127, 1500, 300, 2000, 511);
                4: write_all_regs(5, 3, 1, 300, 1000, 40000, 64);
                default:
                begin
                    own    = $urandom_range(0, 63);
                    nbr    = $urandom_range(0, 7);
                    cols   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(1, 16);
                    thr    = $urandom_range(0, 4095);
                    mdelay = $urandom_range(0, 65535);
                    mest   = $urandom_range(0, 65535);
                    alpha  = $urandom_range(0, 511);
                    write_all_regs(own, nbr, cols, thr, mdelay, mest, alpha);
                end
            endcase

            // Hot destinations: the own tile (checker tracks it) plus a few others,
            // so updates, routes and queries keep hitting the same columns
            hot_dest[0] = (phase == 1) ? 63 : (phase == 2) ? 27 : (phase == 3) ? 9 :
                          (phase == 4) ? 5 : own;
            for (int h = 1; h < 4; h++)
                hot_dest[h] = $urandom_range(0, 63);

            // Phase four runs with no idling at all
            tx_idle_on = (phase != 4);
            rx_idle_on = (phase != 4);

            for (int k = 0; k < 90; k++)
            begin
                // A stretch without idling inside every phase
                if (phase != 4)
                begin
                    tx_idle_on = !(k >= 30 && k < 50);
                    rx_idle_on = tx_idle_on;
                end
                // Hold off mid-phase until every reply is back
                if (k == 60)
                    drain_replies();

                r = $urandom_range(0, 99);
                if (r < 40)      req = REQ_UPDATE;
                else if (r < 75) req = REQ_ROUTE;
                else if (r < 95) req = REQ_QUERY;
                else             req = REQ_UNKNOWN;

                dest = ($urandom_range(0, 99) < 70) ? hot_dest[$urandom_range(0, 3)]
                                                    : $urandom_range(0, 63);
                if (req == REQ_ROUTE)
                    dir = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 7);
                else if (req == REQ_UPDATE)
                    dir = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 7);
                else
                    dir = $urandom_range(0, 7);
                rnd = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2999)
                                                  : $urandom_range(0, 4095);

                send_request(req, dir, dest, rnd, pick_amount(), pick_amount());
            end
            drain_replies();
        end

        // Let any straggler reply show up before the verdict
        repeat (40) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard limit on the run
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/qlmr_pkg.sv
rtl/qlmr_div.sv
rtl/qlmr_datapath.sv
rtl/qlmr_ctrl.sv
rtl/q_learning_mesh_router_top.sv
sim/qlmr_reply_checker.sv
sim/tb_q_learning_mesh_router_top.sv
